[rtl/core/ple_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, codes and controller-datapath interface types of the positional list engine.
package ple_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic ptr_ins;
    logic ptr_del;
    logic ptr_rd;
    logic ptr_loc;
    logic rd;
    logic shift;
    logic put;
    logic inc;
    logic dec;
    logic clr;
    logic take;
    logic found;
    logic set_range;
    logic set_full;
    logic publish;
  } ple_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_ok;
    logic            pos_ok;
    logic            full;
    logic            empty;
    logic            ins_tail;
    logic            del_tail;
    logic            at_lo;
    logic            at_hi;
    logic            hit;
  } ple_sts_t;

endpackage

[rtl/core/positional_list_engine.sv]
`timescale 1ns / 1ps
// Top level of the positional list engine; one item is worked on at a time.
// Clear, unknown operations, rejected items and empty locates finish without a memory access;
// a tail insert or tail delete moves no entries, a read reads one entry, an insert or delete
// moves the entries behind its position, one memory read and write per cycle, and a locate
// walks the list from the head until a hit or the last entry.
// Synchronous active-low reset empties the list; entry contents are left as they are.
module positional_list_engine #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ple_pkg::OP_W-1:0]         in_operation,
  input  logic [ple_pkg::POS_W-1:0]        in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ple_pkg::ST_W-1:0]         out_status,
  output logic signed [ple_pkg::VAL_W-1:0] out_read_value,
  output logic [ple_pkg::POS_W-1:0]        out_found_position,
  output logic [ple_pkg::LEN_W-1:0]        out_length,
  output logic                             out_is_empty
);
  import ple_pkg::*;

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ple_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_length         (out_length),
    .out_is_empty       (out_is_empty)
  );

endmodule

[rtl/core/ple_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the positional list engine: entry memory, list length, walk pointer and result registers.
module ple_datapath #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ple_pkg::ple_cmd_t               cmd,
  output ple_pkg::ple_sts_t               sts,
  input  logic [ple_pkg::OP_W-1:0]        in_operation,
  input  logic [ple_pkg::POS_W-1:0]       in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_value,
  output logic [ple_pkg::ST_W-1:0]        out_status,
  output logic signed [ple_pkg::VAL_W-1:0] out_read_value,
  output logic [ple_pkg::POS_W-1:0]       out_found_position,
  output logic [ple_pkg::LEN_W-1:0]       out_length,
  output logic                            out_is_empty
);
  import ple_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int SW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    mem_q_r;
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [SW-1:0]    val_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    ptr_r;
  logic             q_vld_r;
  logic             q_mv_r;
  logic [AW-1:0]    q_addr_r;
  logic [ST_W-1:0]  res_status_r;
  logic [SW-1:0]    res_rd_r;
  logic [POS_W-1:0] res_found_r;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_m1;
  logic [XW-1:0] cnt_m1;
  logic [XW-1:0] cnt_p1;
  logic          ins_dir;
  logic [AW-1:0] mv_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [AW:0]   found_x;

  always_comb begin
    pos_x   = XW'(pos_r);
    cnt_x   = XW'(count_r);
    pos_m1  = pos_x - XW'(1);
    cnt_m1  = cnt_x - XW'(1);
    cnt_p1  = cnt_x + XW'(1);
    ins_dir = (op_r == OP_INSERT);
    mv_addr = ins_dir ? (q_addr_r + AW'(1)) : (q_addr_r - AW'(1));
    wr_en   = q_mv_r | cmd.put;
    wr_addr = cmd.put ? pos_m1[AW-1:0] : mv_addr;
    wr_data = cmd.put ? val_r : mem_q_r;
    found_x = {1'b0, q_addr_r} + (AW + 1)'(1);

    sts.op       = op_r;
    sts.ins_ok   = (pos_x != '0) && (pos_x <= cnt_p1);
    sts.pos_ok   = (pos_x != '0) && (pos_x <= cnt_x);
    sts.full     = (cnt_x == XW'(DEPTH));
    sts.empty    = (count_r == '0);
    sts.ins_tail = (pos_x == cnt_p1);
    sts.del_tail = (pos_x == cnt_x);
    sts.at_lo    = (ptr_r == pos_m1[AW-1:0]);
    sts.at_hi    = (ptr_r == cnt_m1[AW-1:0]);
    sts.hit      = q_vld_r && !q_mv_r && (mem_q_r == val_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      q_vld_r <= 1'b0;
      q_mv_r  <= 1'b0;
    end else begin
      q_vld_r <= cmd.rd;
      q_mv_r  <= cmd.rd & cmd.shift;
      if (cmd.clr) begin
        count_r <= '0;
      end else if (cmd.inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value[SW-1:0];
    end
    if (cmd.ptr_ins) begin
      ptr_r <= cnt_m1[AW-1:0];
    end else if (cmd.ptr_del) begin
      ptr_r <= pos_x[AW-1:0];
    end else if (cmd.ptr_rd) begin
      ptr_r <= pos_m1[AW-1:0];
    end else if (cmd.ptr_loc) begin
      ptr_r <= '0;
    end else if (cmd.rd) begin
      ptr_r <= ins_dir ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    if (cmd.rd) begin
      q_addr_r <= ptr_r;
    end

    if (cmd.load) begin
      res_status_r <= ST_OK;
      res_rd_r     <= '0;
      res_found_r  <= '0;
    end else begin
      if (cmd.set_range) begin
        res_status_r <= ST_RANGE;
      end else if (cmd.set_full) begin
        res_status_r <= ST_FULL;
      end
      if (cmd.take) begin
        res_rd_r <= mem_q_r;
      end
      if (cmd.found) begin
        res_found_r <= POS_W'(found_x);
      end
    end

    if (cmd.publish) begin
      out_status         <= res_status_r;
      out_read_value     <= VAL_W'(res_rd_r);
      out_found_position <= res_found_r;
      out_length         <= LEN_W'(count_r);
      out_is_empty       <= (count_r == '0);
    end
  end

endmodule

[rtl/core/ple_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the positional list engine: request sequencing and the item handshakes.
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ple_pkg::ple_sts_t sts,
  output ple_pkg::ple_cmd_t cmd
);
  import ple_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_WALK,
    S_INS_DRAIN,
    S_PUT,
    S_DEL_WALK,
    S_DEL_DRAIN,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_LOC_WALK,
    S_LOC_LAST,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (sts.op)
          OP_INSERT: begin
            if (!sts.ins_ok) begin
              cmd.set_range = 1'b1;
            end else if (sts.full) begin
              cmd.set_full = 1'b1;
            end else if (sts.ins_tail) begin
              state_nxt = S_PUT;
            end else begin
              cmd.ptr_ins = 1'b1;
              state_nxt   = S_INS_WALK;
            end
          end
          OP_DELETE: begin
            if (!sts.pos_ok) begin
              cmd.set_range = 1'b1;
            end else if (sts.del_tail) begin
              state_nxt = S_DEL_DRAIN;
            end else begin
              cmd.ptr_del = 1'b1;
              state_nxt   = S_DEL_WALK;
            end
          end
          OP_READ: begin
            if (!sts.pos_ok) begin
              cmd.set_range = 1'b1;
            end else begin
              cmd.ptr_rd = 1'b1;
              state_nxt  = S_RD_ISSUE;
            end
          end
          OP_LOCATE: begin
            if (!sts.empty) begin
              cmd.ptr_loc = 1'b1;
              state_nxt   = S_LOC_WALK;
            end
          end
          OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_INS_WALK: begin
        cmd.rd    = 1'b1;
        cmd.shift = 1'b1;
        if (sts.at_lo) begin
          state_nxt = S_INS_DRAIN;
        end
      end
      S_INS_DRAIN: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        cmd.inc   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_DEL_WALK: begin
        cmd.rd    = 1'b1;
        cmd.shift = 1'b1;
        if (sts.at_hi) begin
          state_nxt = S_DEL_DRAIN;
        end
      end
      S_DEL_DRAIN: begin
        cmd.dec   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_RD_ISSUE: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd.take  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_LOC_WALK: begin
        if (sts.hit) begin
          cmd.found = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.rd = 1'b1;
          if (sts.at_hi) begin
            state_nxt = S_LOC_LAST;
          end
        end
      end
      S_LOC_LAST: begin
        cmd.found = sts.hit;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/ple_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the positional list engine and their binding to the top level.
module ple_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [ple_pkg::ST_W-1:0]         out_status,
  input logic signed [ple_pkg::VAL_W-1:0] out_read_value,
  input logic [ple_pkg::POS_W-1:0]        out_found_position,
  input logic [ple_pkg::LEN_W-1:0]        out_length,
  input logic                             out_is_empty
);
  import ple_pkg::*;

  // Only one item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_RANGE) ||
                  (out_status == ST_FULL))
    else $error("undefined status code");

  // A rejected request carries neither read data nor a found position.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_read_value == '0) &&
                                           (out_found_position == '0))
    else $error("rejected item carries data");

  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_length == '0))
    else $error("empty flag with nonzero length");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_read_value) && $stable(out_found_position) &&
                               $stable(out_length) && $stable(out_is_empty))
    else $error("stalled result item changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
